>>> hdl/zsc_pkg.sv
package zsc_pkg;

    localparam int DEF_MAX_VIRT_WIDTH  = 256;
    localparam int DEF_MAX_VIRT_HEIGHT = 256;

    localparam int COLOR_W = 32;
    localparam int DEPTH_W = 16;
    localparam int WORD_W  = COLOR_W + DEPTH_W;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int ORG_W   = 13;
    localparam int OFS_W   = 12;
    localparam int VSIZE_W = 9;
    localparam int OSIZE_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 104;

    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PLOT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [STAT_W-1:0] ST_DRAWN   = 3'd0;
    localparam logic [STAT_W-1:0] ST_CLIPPED = 3'd1;
    localparam logic [STAT_W-1:0] ST_HIDDEN  = 3'd2;
    localparam logic [STAT_W-1:0] ST_READ_OK = 3'd3;
    localparam logic [STAT_W-1:0] ST_OTHER   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_VIRT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIRT_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT  = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PLOT_CHK,
        S_PLOT_RD,
        S_PLOT_CMP,
        S_RD_MUL,
        S_RD_DIV,
        S_RD_ADDR,
        S_RD_RD,
        S_RD_DATA,
        S_DONE
    } state_t;

endpackage

>>> hdl/zsc_ram.sv
module zsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hdl/zbuffer_sprite_compositor.sv
// z-buffered sprite compositor: a virtual canvas of rgba colors with a signed 16-bit
// depth per pixel, held together in one single-port ram of MAX_VIRT_WIDTH x
// MAX_VIRT_HEIGHT words. one item is worked at a time and each gives exactly one
// result item. a plot goes through bound check and address, ram read, compare and
// write back, and result register; a clipped plot goes from the bound check straight
// to the result register. a read runs the PW steps of the bit-serial dividers that do
// the nearest-neighbor scaling (21 at the defaults); a read outside the output size
// and an unused command go straight to the result register. a clear sweeps the
// whole ram one word a cycle, all MAX_VIRT_WIDTH * MAX_VIRT_HEIGHT words (65536 at
// the defaults), and then answers status 4. the same sweep runs after reset, with
// no result, while s_tready stays low; config writes are always taken. the result
// sits in an output register, so the next item is taken while it waits.
module zbuffer_sprite_compositor
    import zsc_pkg::*;
#(
    parameter int MAX_VIRT_WIDTH  = DEF_MAX_VIRT_WIDTH,
    parameter int MAX_VIRT_HEIGHT = DEF_MAX_VIRT_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // origin_x[12:0], origin_y[25:13], offset_col[37:26], offset_row[49:38],
    // pixel_depth[65:50], pixel_color[97:66], zero fill up to 103
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]      s_tuser,
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // read_color[31:0]
    output logic [COLOR_W-1:0]    m_tdata,
    // status[2:0]
    output logic [STAT_W-1:0]     m_tuser,
    // config writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int MEM_DEPTH = MAX_VIRT_WIDTH * MAX_VIRT_HEIGHT;
    localparam int IDX_W     = $clog2(MEM_DEPTH);
    localparam int X_W       = $clog2(MAX_VIRT_WIDTH);
    localparam int Y_W       = $clog2(MAX_VIRT_HEIGHT);
    localparam int VW_W      = $clog2(MAX_VIRT_WIDTH + 1);
    localparam int VH_W      = $clog2(MAX_VIRT_HEIGHT + 1);
    localparam int PWX       = OFS_W + VW_W;
    localparam int PWY       = OFS_W + VH_W;
    localparam int PW        = (PWX > PWY) ? PWX : PWY;
    localparam int CNT_W     = $clog2(PW + 1);
    localparam int FX_W      = ORG_W + 1;

    // configuration registers
    logic [VSIZE_W-1:0] virt_width_reg, virt_height_reg;
    logic [OSIZE_W-1:0] out_width_reg, out_height_reg;

    // control
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               clr_reply_reg, clr_reply_next;
    logic [CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic               out_valid_reg, out_valid_next;

    // item and datapath
    logic signed [ORG_W-1:0]   ox_reg, ox_next, oy_reg, oy_next;
    logic [OFS_W-1:0]          col_reg, col_next, row_reg, row_next;
    logic signed [DEPTH_W-1:0] pdepth_reg, pdepth_next;
    logic [COLOR_W-1:0]        pcolor_reg, pcolor_next;
    logic [IDX_W-1:0]          addr_reg, addr_next;
    logic [PW-1:0]             dvx_reg, dvx_next, dvy_reg, dvy_next;
    logic [OSIZE_W-1:0]        remx_reg, remx_next, remy_reg, remy_next;
    logic [STAT_W-1:0]         stat_reg, stat_next;
    logic [COLOR_W-1:0]        rcolor_reg, rcolor_next;
    logic [STAT_W-1:0]         out_stat_reg, out_stat_next;
    logic [COLOR_W-1:0]        out_color_reg, out_color_next;

    // ram port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;

    // clamped virtual size
    logic [VW_W-1:0] vw;
    logic [VH_W-1:0] vh;

    // plot coordinates
    logic signed [FX_W-1:0] fx, fy;
    logic                   clipped;
    logic                   out_free;

    // divider step
    logic [OSIZE_W:0] remx_sh, remy_sh;
    logic             gex, gey;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_color_reg;
    assign m_tuser   = out_stat_reg;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        if (virt_width_reg == '0)
            vw = VW_W'(1);
        else if (VW_W'(virt_width_reg) > VW_W'(MAX_VIRT_WIDTH)
                 || (VW_W < VSIZE_W && (virt_width_reg >> VW_W) != '0))
            vw = VW_W'(MAX_VIRT_WIDTH);
        else
            vw = VW_W'(virt_width_reg);
        if (virt_height_reg == '0)
            vh = VH_W'(1);
        else if (VH_W'(virt_height_reg) > VH_W'(MAX_VIRT_HEIGHT)
                 || (VH_W < VSIZE_W && (virt_height_reg >> VH_W) != '0))
            vh = VH_W'(MAX_VIRT_HEIGHT);
        else
            vh = VH_W'(virt_height_reg);
    end

    // sprite pixel position, one add per axis
    assign fx = FX_W'(ox_reg) + FX_W'({2'b00, col_reg});
    assign fy = FX_W'(oy_reg) + FX_W'({2'b00, row_reg});
    assign clipped = fx[FX_W-1] || fy[FX_W-1]
                     || ($unsigned(fx) >= FX_W'(vw)) || ($unsigned(fy) >= FX_W'(vh));

    // restoring divide step, quotient bits shift into the dividend register
    assign remx_sh = {remx_reg, dvx_reg[PW-1]};
    assign remy_sh = {remy_reg, dvy_reg[PW-1]};
    assign gex = remx_sh >= {1'b0, out_width_reg};
    assign gey = remy_sh >= {1'b0, out_height_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(MEM_DEPTH - 1))
                    state_next = clr_reply_reg ? S_DONE : S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (s_tuser)
                        CMD_CLEAR: state_next = S_CLEAR;
                        CMD_PLOT:  state_next = S_PLOT_CHK;
                        CMD_READ:  state_next = S_RD_MUL;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_PLOT_CHK: state_next = clipped ? S_DONE : S_PLOT_RD;
            S_PLOT_RD:  state_next = S_PLOT_CMP;
            S_PLOT_CMP: state_next = S_DONE;
            S_RD_MUL:
            begin
                if (col_reg >= out_width_reg || row_reg >= out_height_reg)
                    state_next = S_DONE;
                else
                    state_next = S_RD_DIV;
            end
            S_RD_DIV:
            begin
                if (div_cnt_reg == CNT_W'(PW - 1))
                    state_next = S_RD_ADDR;
            end
            S_RD_ADDR: state_next = S_RD_RD;
            S_RD_RD:   state_next = S_RD_DATA;
            S_RD_DATA: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        div_cnt_next   = div_cnt_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        pdepth_next    = pdepth_reg;
        pcolor_next    = pcolor_reg;
        addr_next      = addr_reg;
        dvx_next       = dvx_reg;
        dvy_next       = dvy_reg;
        remx_next      = remx_reg;
        remy_next      = remy_reg;
        stat_next      = stat_reg;
        rcolor_next    = rcolor_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_stat_next  = out_stat_reg;
        out_color_next = out_color_reg;
        ram_we         = 1'b0;
        ram_addr       = addr_reg;
        ram_wdata      = {pdepth_reg, pcolor_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = {DEPTH_MIN, {COLOR_W{1'b0}}};
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                stat_next    = ST_OTHER;
                rcolor_next  = '0;
            end
            S_IDLE:
            begin
                ox_next        = s_tdata[12:0];
                oy_next        = s_tdata[25:13];
                col_next       = s_tdata[37:26];
                row_next       = s_tdata[49:38];
                pdepth_next    = s_tdata[65:50];
                pcolor_next    = s_tdata[97:66];
                stat_next      = ST_OTHER;
                rcolor_next    = '0;
                clr_cnt_next   = '0;
                clr_reply_next = 1'b1;
            end
            S_PLOT_CHK:
            begin
                stat_next = ST_CLIPPED;
                addr_next = IDX_W'(fy[Y_W-1:0]) * IDX_W'(MAX_VIRT_WIDTH)
                            + IDX_W'(fx[X_W-1:0]);
            end
            S_PLOT_RD:
            begin
                ram_addr = addr_reg;
            end
            S_PLOT_CMP:
            begin
                // stored depth sits in the upper bits of the word
                if ($signed(ram_rdata[WORD_W-1:COLOR_W]) > pdepth_reg)
                begin
                    stat_next = ST_HIDDEN;
                end
                else
                begin
                    ram_we    = 1'b1;
                    stat_next = ST_DRAWN;
                end
            end
            S_RD_MUL:
            begin
                dvx_next     = PW'(col_reg) * PW'(vw);
                dvy_next     = PW'(row_reg) * PW'(vh);
                remx_next    = '0;
                remy_next    = '0;
                div_cnt_next = '0;
            end
            S_RD_DIV:
            begin
                remx_next    = gex ? OSIZE_W'(remx_sh - {1'b0, out_width_reg})
                                   : OSIZE_W'(remx_sh);
                remy_next    = gey ? OSIZE_W'(remy_sh - {1'b0, out_height_reg})
                                   : OSIZE_W'(remy_sh);
                dvx_next     = {dvx_reg[PW-2:0], gex};
                dvy_next     = {dvy_reg[PW-2:0], gey};
                div_cnt_next = div_cnt_reg + CNT_W'(1);
            end
            S_RD_ADDR:
            begin
                addr_next = IDX_W'(dvy_reg[Y_W-1:0]) * IDX_W'(MAX_VIRT_WIDTH)
                            + IDX_W'(dvx_reg[X_W-1:0]);
            end
            S_RD_RD:
            begin
                ram_addr = addr_reg;
            end
            S_RD_DATA:
            begin
                rcolor_next = ram_rdata[COLOR_W-1:0];
                stat_next   = ST_READ_OK;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_color_next = rcolor_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            clr_reply_reg   <= 1'b0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            virt_width_reg  <= VSIZE_W'(256);
            virt_height_reg <= VSIZE_W'(256);
            out_width_reg   <= OSIZE_W'(256);
            out_height_reg  <= OSIZE_W'(256);
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_VIRT_WIDTH:  virt_width_reg  <= cfg_data[VSIZE_W-1:0];
                    REG_VIRT_HEIGHT: virt_height_reg <= cfg_data[VSIZE_W-1:0];
                    REG_OUT_WIDTH:   out_width_reg   <= cfg_data;
                    REG_OUT_HEIGHT:  out_height_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ox_reg        <= ox_next;
        oy_reg        <= oy_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        pdepth_reg    <= pdepth_next;
        pcolor_reg    <= pcolor_next;
        addr_reg      <= addr_next;
        dvx_reg       <= dvx_next;
        dvy_reg       <= dvy_next;
        remx_reg      <= remx_next;
        remy_reg      <= remy_next;
        stat_reg      <= stat_next;
        rcolor_reg    <= rcolor_next;
        out_stat_reg  <= out_stat_next;
        out_color_reg <= out_color_next;
    end

    // color and depth of each pixel share one word
    zsc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

>>> hdl/zsc_check.sv
module zsc_check
    import zsc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [CMD_W-1:0]      s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [COLOR_W-1:0]    m_tdata,
    input logic [STAT_W-1:0]     m_tuser,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // color is zero unless a valid read
    a_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_READ_OK |-> m_tdata == '0)
        else $error("nonzero color on non-read result");

    // status code in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= ST_OTHER)
        else $error("bad status code");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while one is in work");

endmodule

bind zbuffer_sprite_compositor zsc_check u_zsc_check (.*);
